FILE: rtl/jutf8_pkg.sv
// shared types, constants and helper functions for the modified utf-8 name decoder
`default_nettype none

package jutf8_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [15:0] SUR_HIGH_LO = 16'hD800;
  localparam logic [15:0] SUR_HIGH_HI = 16'hDBFF;
  localparam logic [15:0] SUR_LOW_LO  = 16'hDC00;
  localparam logic [15:0] SUR_LOW_HI  = 16'hDFFF;
  localparam logic [15:0] REPL_CHAR   = 16'hFFFD;
  localparam logic [20:0] SUPP_BASE   = 21'h10000;
  localparam logic [15:0] ZERO_SUBST  = 16'h005F;
  localparam logic [15:0] CTRL_LIMIT  = 16'h0020;
  localparam logic [15:0] C1_LO       = 16'h007F;
  localparam logic [15:0] C1_HI       = 16'h009F;

  localparam logic [1:0] SEG_FIRST  = 2'd0;
  localparam logic [1:0] SEG_SECOND = 2'd1;
  localparam logic [1:0] SEG_REPL   = 2'd2;
  localparam logic [1:0] SEG_STATUS = 2'd3;

  // one decoded input byte's worth of work for the back end
  typedef struct packed {
    logic        e1_valid;
    logic [20:0] e1_code;
    logic        e2_valid;
    logic [15:0] e2_code;
    logic        e3_valid;
    logic        st_valid;
    logic        st_name_valid;
    logic        st_name_safe;
  } job_t;

  function automatic logic is_unsafe(input logic [15:0] c);
    logic r;
    r = (c < CTRL_LIMIT) || ((c >= C1_LO) && (c <= C1_HI)) ||
        (c == 16'h002F) || (c == 16'h005C) || (c == 16'h003A) || (c == 16'h002A) ||
        (c == 16'h003F) || (c == 16'h0022) || (c == 16'h003C) || (c == 16'h003E) ||
        (c == 16'h007C);
    return r;
  endfunction

  function automatic logic [1:0] utf8_len_m1(input logic [20:0] code);
    logic [1:0] n;
    if (code < 21'h80) begin
      n = 2'd0;
    end else if (code < 21'h800) begin
      n = 2'd1;
    end else if (code < 21'h10000) begin
      n = 2'd2;
    end else begin
      n = 2'd3;
    end
    return n;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] code, input logic [1:0] len_m1,
                                           input logic [1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    unique case (len_m1)
      2'd0: b = code[7:0];
      2'd1: b = (idx == 2'd0) ? {3'b110, code[10:6]} : {2'b10, code[5:0]};
      2'd2: begin
        unique case (idx)
          2'd0:    b = {4'b1110, code[15:12]};
          2'd1:    b = {2'b10, code[11:6]};
          default: b = {2'b10, code[5:0]};
        endcase
      end
      default: begin
        unique case (idx)
          2'd0:    b = {5'b11110, code[20:18]};
          2'd1:    b = {2'b10, code[17:12]};
          2'd2:    b = {2'b10, code[11:6]};
          default: b = {2'b10, code[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/jutf8_front.sv
// front end: decodes input bytes, tracks sequence and surrogate state, builds jobs
`default_nettype none

module jutf8_front
  import jutf8_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] in_byte,
  input  wire logic       last,
  output job_t            job,
  output logic            job_push
);

  logic [15:0] partial_code, partial_code_next;
  logic [1:0]  bytes_remaining, bytes_remaining_next;
  logic        hs_pending, hs_pending_next;
  logic [9:0]  hs_bits, hs_bits_next;
  logic        safe_flag, safe_flag_next;
  logic        error_flag, error_flag_next;

  logic        have_c;
  logic        take_c;
  logic [15:0] c;

  always_comb begin
    partial_code_next    = partial_code;
    bytes_remaining_next = bytes_remaining;
    hs_pending_next      = hs_pending;
    hs_bits_next         = hs_bits;
    safe_flag_next       = safe_flag;
    error_flag_next      = error_flag;
    have_c               = 1'b0;
    take_c               = 1'b0;
    c                    = 16'h0000;
    job                  = '0;

    // byte level decode
    if (!error_flag) begin
      if (bytes_remaining != 2'd0) begin
        if (in_byte[7:6] != 2'b10) begin
          error_flag_next = 1'b1;
        end else begin
          partial_code_next    = {partial_code[9:0], in_byte[5:0]};
          bytes_remaining_next = bytes_remaining - 2'd1;
          if (bytes_remaining == 2'd1) begin
            have_c            = 1'b1;
            c                 = partial_code_next;
            partial_code_next = 16'h0000;
          end
        end
      end else if (in_byte == 8'h00) begin
        error_flag_next = 1'b1;
      end else if (!in_byte[7]) begin
        have_c = 1'b1;
        c      = {8'h00, in_byte};
      end else if (in_byte[7:5] == 3'b110) begin
        partial_code_next    = {11'b0, in_byte[4:0]};
        bytes_remaining_next = 2'd1;
      end else if (in_byte[7:4] == 4'b1110) begin
        partial_code_next    = {12'b0, in_byte[3:0]};
        bytes_remaining_next = 2'd2;
      end else begin
        error_flag_next = 1'b1;
      end
    end

    // code point handling
    if (have_c) begin
      take_c = 1'b1;
      if (hs_pending) begin
        hs_pending_next = 1'b0;
        hs_bits_next    = 10'h000;
        job.e1_valid    = 1'b1;
        if ((c >= SUR_LOW_LO) && (c <= SUR_LOW_HI)) begin
          job.e1_code = SUPP_BASE + {1'b0, hs_bits, c[9:0]};
          take_c      = 1'b0;
        end else begin
          job.e1_code    = {5'b0, REPL_CHAR};
          safe_flag_next = 1'b0;
        end
      end
      if (take_c) begin
        if ((c >= SUR_HIGH_LO) && (c <= SUR_HIGH_HI)) begin
          hs_pending_next = 1'b1;
          hs_bits_next    = c[9:0];
        end else begin
          job.e2_valid = 1'b1;
          if ((c >= SUR_LOW_LO) && (c <= SUR_LOW_HI)) begin
            job.e2_code    = REPL_CHAR;
            safe_flag_next = 1'b0;
          end else if (c == 16'h0000) begin
            job.e2_code    = ZERO_SUBST;
            safe_flag_next = 1'b0;
          end else begin
            job.e2_code = c;
            if (is_unsafe(c)) begin
              safe_flag_next = 1'b0;
            end
          end
        end
      end
    end

    // end of name
    if (last) begin
      if (!error_flag_next && (bytes_remaining_next != 2'd0)) begin
        error_flag_next = 1'b1;
      end
      if (!error_flag_next && hs_pending_next) begin
        job.e3_valid   = 1'b1;
        safe_flag_next = 1'b0;
      end
      job.st_valid      = 1'b1;
      job.st_name_valid = !error_flag_next;
      job.st_name_safe  = !error_flag_next && safe_flag_next;
    end
  end

  assign job_push = accept && (job.e1_valid || job.e2_valid || job.e3_valid || job.st_valid);

  always_ff @(posedge clk) begin
    if (rst || (accept && last)) begin
      partial_code    <= 16'h0000;
      bytes_remaining <= 2'd0;
      hs_pending      <= 1'b0;
      hs_bits         <= 10'h000;
      safe_flag       <= 1'b1;
      error_flag      <= 1'b0;
    end else if (accept) begin
      partial_code    <= partial_code_next;
      bytes_remaining <= bytes_remaining_next;
      hs_pending      <= hs_pending_next;
      hs_bits         <= hs_bits_next;
      safe_flag       <= safe_flag_next;
      error_flag      <= error_flag_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/jutf8_queue.sv
// small job queue between the front end and the back end
`default_nettype none

module jutf8_queue
  import jutf8_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  wire job_t wr_job,
  output logic      full,
  input  wire logic rd_en,
  output job_t      rd_job,
  output logic      q_empty
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  job_t            mem [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  logic do_wr;
  logic do_rd;

  assign full    = (count == CntW'(QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_job  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/jutf8_back.sv
// back end: expands jobs into utf-8 bytes and status items, one per cycle while pop keeps up
`default_nettype none

module jutf8_back
  import jutf8_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire job_t       head_job,
  input  wire logic       q_empty,
  output logic            q_pop,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic            is_status,
  output logic            name_valid,
  output logic            name_safe,
  output logic            end_of_run
);

  job_t       cur;
  logic [3:0] seg_live;
  logic [1:0] idx;
  logic       out_valid;

  logic [1:0]  seg_sel;
  logic [20:0] code;
  logic [1:0]  len_m1;
  logic        seg_done;
  logic [3:0]  seg_after;
  logic        is_final;
  logic        emit;
  logic        load;

  always_comb begin
    if (seg_live[0]) begin
      seg_sel = SEG_FIRST;
    end else if (seg_live[1]) begin
      seg_sel = SEG_SECOND;
    end else if (seg_live[2]) begin
      seg_sel = SEG_REPL;
    end else begin
      seg_sel = SEG_STATUS;
    end
  end

  always_comb begin
    unique case (seg_sel)
      SEG_FIRST:  code = cur.e1_code;
      SEG_SECOND: code = {5'b0, cur.e2_code};
      SEG_REPL:   code = {5'b0, REPL_CHAR};
      default:    code = '0;
    endcase
  end

  assign len_m1    = utf8_len_m1(code);
  assign seg_done  = (seg_sel == SEG_STATUS) || (idx == len_m1);
  assign seg_after = seg_done ? (seg_live & ~(4'b0001 << seg_sel)) : seg_live;
  assign is_final  = seg_done && (seg_after == 4'b0000);

  assign emit  = (seg_live != 4'b0000) && (!out_valid || pop);
  assign load  = !q_empty && ((seg_live == 4'b0000) || (emit && is_final));
  assign q_pop = load;
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_live <= 4'b0000;
      idx      <= 2'd0;
    end else if (load) begin
      seg_live <= {head_job.st_valid, head_job.e3_valid, head_job.e2_valid, head_job.e1_valid};
      idx      <= 2'd0;
    end else if (emit) begin
      seg_live <= seg_after;
      idx      <= seg_done ? 2'd0 : idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= head_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      end_of_run <= is_final;
      if (seg_sel == SEG_STATUS) begin
        out_byte   <= 8'h00;
        is_status  <= 1'b1;
        name_valid <= cur.st_name_valid;
        name_safe  <= cur.st_name_safe;
      end else begin
        out_byte   <= utf8_byte(code, len_m1, idx);
        is_status  <= 1'b0;
        name_valid <= 1'b0;
        name_safe  <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/java_utf8_name_decoder_unit.sv
// top level of the modified utf-8 to standard utf-8 name decoder
`default_nettype none

// Accepts one name byte per clock cycle (push while full is low) and delivers
// one result item per clock cycle (pop while empty is low). The front end
// decodes a byte in the cycle it is accepted and queues at most one job;
// the back end turns each job into its output items, one item per cycle
// while pop keeps up; a job yields 1 to 7 items (1 for plain ascii).
// QUEUE_DEPTH jobs buffer those bursts; full rises only when the queue
// holds that many unfinished jobs. The back end loads a job into its
// current-job register, then registers each result item onto the ports.
// After the byte marked last, a status item ends the name and all decode
// state returns to its reset value. No warm-up after reset is needed.
module java_utf8_name_decoder_unit
  import jutf8_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte,
  input  wire logic       last,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic            is_status,
  output logic            name_valid,
  output logic            name_safe,
  output logic            end_of_run
);

  job_t job;
  job_t head_job;
  logic job_push;
  logic q_pop;
  logic q_empty;
  logic accept;

  assign accept = push && !full;

  jutf8_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_byte  (in_byte),
    .last     (last),
    .job      (job),
    .job_push (job_push)
  );

  jutf8_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_job  (job),
    .full    (full),
    .rd_en   (q_pop),
    .rd_job  (head_job),
    .q_empty (q_empty)
  );

  jutf8_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_job   (head_job),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .is_status  (is_status),
    .name_valid (name_valid),
    .name_safe  (name_safe),
    .end_of_run (end_of_run)
  );

endmodule

`default_nettype wire
